@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files that carry checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BAC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define BAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/bac_pkg.sv @@
// Types and constants for the BCD alarm clock block.
// No dependencies; used by the channel interfaces and the top level.
package bac_pkg;

  typedef enum logic [2:0] {
    MODE_CLOCK        = 3'd0,
    MODE_HOUR         = 3'd1,
    MODE_MINUTE       = 3'd2,
    MODE_ALARM_HOUR   = 3'd3,
    MODE_ALARM_MINUTE = 3'd4,
    MODE_ALARM_EN     = 3'd5,
    MODE_AMPM         = 3'd6
  } bac_mode_e;

  localparam int unsigned KeyW = 3;
  localparam int unsigned TickW = 8;
  localparam logic [TickW-1:0] TicksPerSecondRst = 8'd10;

  typedef struct packed {
    logic [KeyW-1:0] key_levels;
  } bac_in_t;

  typedef struct packed {
    logic            display_update;
    logic [1:0]      shown_hour_tens;
    logic [3:0]      shown_hour_units;
    logic [2:0]      shown_minute_tens;
    logic [3:0]      shown_minute_units;
    logic            status_update;
    logic [2:0]      mode_out;
    logic            alarm_enable_out;
    logic            ampm_out;
    logic            buzzer_start;
    logic            buzzer_stop;
  } bac_out_t;

  typedef struct packed {
    logic [1:0] tens;
    logic [3:0] units;
  } bac_hour_t;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] units;
  } bac_minute_t;

endpackage

@@ rtl/bac_if.sv @@
// Valid/ready channel interfaces: input items, result items, rate register writes.
// Depends on bac_pkg for the payload types.
interface bac_in_if;
  import bac_pkg::*;
  logic    valid;
  logic    ready;
  bac_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bac_out_if;
  import bac_pkg::*;
  logic     valid;
  logic     ready;
  bac_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bac_cfg_if;
  import bac_pkg::*;
  logic             valid;
  logic             ready;
  logic [TickW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/bcd_alarm_clock_with_set_keys_top.sv @@
// 24-hour BCD alarm clock with mode and adjust keys, one item per timer tick.
// Depends on bac_pkg, the channel interfaces in bac_if.sv and assert_macros.svh.

// One input item is one timer tick carrying the raw active-low key levels; each
// item yields exactly one result item. The block takes one item per clock cycle
// while the output is ready: an item is held in the input register, then a single
// pass of counter and compare logic updates the clock state and loads the result
// register, which offers the result on the output. Input ready follows output ready
// combinationally through the two registers. The rate register is written
// through its own channel, which is always ready; write it only while no items
// are in flight.
module bcd_alarm_clock_with_set_keys_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  bac_in_if.sink    item_in_i,
  bac_out_if.source item_out_o,
  bac_cfg_if.sink   cfg_i
);
  import bac_pkg::*;
  `include "assert_macros.svh"

  // configuration
  logic [TickW-1:0] tps_q;

  // pipeline registers
  logic            in_v_q;
  logic [KeyW-1:0] keys_q;
  logic            out_v_q;
  bac_out_t        out_q, out_d;
  logic            adv, fire;

  // clock state
  logic [TickW-1:0] tick_q, tick_d;
  logic [3:0]  sec_u_q, sec_u_d;
  logic [2:0]  sec_t_q, sec_t_d;
  bac_minute_t min_q, min_d;
  bac_hour_t   hour_q, hour_d;
  bac_minute_t amin_q, amin_d;
  bac_hour_t   ahour_q, ahour_d;
  logic [2:0]  mark_q, mark_d;
  logic        ringing_q, ringing_d;
  logic        alarm_on_q, alarm_on_d;
  logic        ampm_q, ampm_d;
  bac_mode_e   mode_q, mode_d;
  logic [KeyW-1:0] prev_keys_q;

  function automatic bac_hour_t hour_step(bac_hour_t h);
    bac_hour_t r;
    r = h;
    r.units = h.units + 4'd1;
    if (r.units > 4'd9) begin
      r.units = 4'd0;
      r.tens  = h.tens + 2'd1;
      if (r.tens > 2'd2) r.tens = 2'd0;
    end
    if (r.tens == 2'd2 && r.units >= 4'd4) begin
      r.tens  = 2'd0;
      r.units = 4'd0;
    end
    return r;
  endfunction

  function automatic bac_minute_t minute_step(bac_minute_t m);
    bac_minute_t r;
    r = m;
    r.units = m.units + 4'd1;
    if (r.units > 4'd9) begin
      r.units = 4'd0;
      r.tens  = m.tens + 3'd1;
      if (r.tens > 3'd5) r.tens = 3'd0;
    end
    return r;
  endfunction

  assign adv  = !out_v_q || item_out_o.ready;
  assign fire = in_v_q && adv;

  assign item_in_i.ready  = !in_v_q || adv;
  assign item_out_o.valid = out_v_q;
  assign item_out_o.data  = out_q;
  assign cfg_i.ready      = 1'b1;

  always_comb begin
    logic redraw, bstart, bstop, changed;
    redraw     = 1'b0;
    bstart     = 1'b0;
    bstop      = 1'b0;
    tick_d     = tick_q + 8'd1;
    sec_u_d    = sec_u_q;
    sec_t_d    = sec_t_q;
    min_d      = min_q;
    hour_d     = hour_q;
    amin_d     = amin_q;
    ahour_d    = ahour_q;
    mark_d     = mark_q;
    ringing_d  = ringing_q;
    alarm_on_d = alarm_on_q;
    ampm_d     = ampm_q;
    mode_d     = mode_q;

    // one second passes
    if (tick_d >= tps_q) begin
      tick_d  = '0;
      sec_u_d = sec_u_q + 4'd1;
      if (sec_u_d >= 4'd10) begin
        sec_t_d = sec_t_q + 3'd1;
        sec_u_d = 4'd0;
      end
      if (sec_t_d >= 3'd6) begin
        min_d.units = min_q.units + 4'd1;
        sec_t_d     = 3'd0;
        redraw      = 1'b1;
      end
      if (min_d.units >= 4'd10) begin
        min_d.tens  = min_q.tens + 3'd1;
        min_d.units = 4'd0;
      end
      if (min_d.tens >= 3'd6) begin
        hour_d.units = hour_q.units + 4'd1;
        min_d.tens   = 3'd0;
      end
      if (hour_d.units >= 4'd10) begin
        hour_d.tens  = hour_q.tens + 2'd1;
        hour_d.units = 4'd0;
      end
      if (hour_d.tens == 2'd2 && hour_d.units >= 4'd4) begin
        hour_d.tens  = 2'd0;
        hour_d.units = 4'd0;
      end

      // buzzer sounds from units 1 until tens has moved up by one
      if (ringing_q) begin
        if (sec_u_d == 4'd1) begin
          bstart = 1'b1;
          mark_d = sec_t_d;
        end
        if ({1'b0, sec_t_d} == {1'b0, mark_d} + 4'd1 && sec_u_d == 4'd0) begin
          ringing_d = 1'b0;
          bstop     = 1'b1;
        end
      end
      if (alarm_on_q && hour_d == ahour_q && min_d == amin_q &&
          sec_t_d == 3'd0 && sec_u_d == 4'd0) begin
        ringing_d = 1'b1;
        mark_d    = 3'd0;
      end
    end

    changed = keys_q != prev_keys_q;
    if (changed) begin
      // mode key first, then adjust acts in the new mode
      if (!keys_q[0]) begin
        if (mode_q == MODE_MINUTE || mode_q == MODE_ALARM_MINUTE) redraw = 1'b1;
        unique case (mode_q)
          MODE_CLOCK:        mode_d = MODE_HOUR;
          MODE_HOUR:         mode_d = MODE_MINUTE;
          MODE_MINUTE:       mode_d = MODE_ALARM_HOUR;
          MODE_ALARM_HOUR:   mode_d = MODE_ALARM_MINUTE;
          MODE_ALARM_MINUTE: mode_d = MODE_ALARM_EN;
          MODE_ALARM_EN:     mode_d = MODE_AMPM;
          default:           mode_d = MODE_CLOCK;
        endcase
      end
      if (!keys_q[1]) begin
        unique case (mode_d)
          MODE_CLOCK: ringing_d = 1'b1;
          MODE_HOUR: begin
            redraw = 1'b1;
            hour_d = hour_step(hour_d);
          end
          MODE_MINUTE: begin
            redraw = 1'b1;
            min_d  = minute_step(min_d);
          end
          MODE_ALARM_HOUR: begin
            redraw  = 1'b1;
            ahour_d = hour_step(ahour_q);
          end
          MODE_ALARM_MINUTE: begin
            redraw = 1'b1;
            amin_d = minute_step(amin_q);
          end
          MODE_ALARM_EN: alarm_on_d = !alarm_on_q;
          MODE_AMPM:     ampm_d     = !ampm_q;
          default: ;
        endcase
      end
    end

    out_d                    = '0;
    out_d.display_update     = redraw;
    if (redraw) begin
      if (mode_d == MODE_ALARM_HOUR || mode_d == MODE_ALARM_MINUTE) begin
        out_d.shown_hour_tens    = ahour_d.tens;
        out_d.shown_hour_units   = ahour_d.units;
        out_d.shown_minute_tens  = amin_d.tens;
        out_d.shown_minute_units = amin_d.units;
      end else begin
        out_d.shown_hour_tens    = hour_d.tens;
        out_d.shown_hour_units   = hour_d.units;
        out_d.shown_minute_tens  = min_d.tens;
        out_d.shown_minute_units = min_d.units;
      end
    end
    out_d.status_update    = changed;
    out_d.mode_out         = mode_d;
    out_d.alarm_enable_out = alarm_on_d;
    out_d.ampm_out         = ampm_d;
    out_d.buzzer_start     = bstart;
    out_d.buzzer_stop      = bstop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q       <= TicksPerSecondRst;
      in_v_q      <= 1'b0;
      out_v_q     <= 1'b0;
      tick_q      <= '0;
      sec_u_q     <= 4'd0;
      sec_t_q     <= 3'd0;
      min_q       <= '{tens: 3'd1, units: 4'd4};
      hour_q      <= '{tens: 2'd2, units: 4'd0};
      amin_q      <= '{tens: 3'd0, units: 4'd1};
      ahour_q     <= '{tens: 2'd2, units: 4'd3};
      mark_q      <= 3'd0;
      ringing_q   <= 1'b0;
      alarm_on_q  <= 1'b1;
      ampm_q      <= 1'b1;
      mode_q      <= MODE_CLOCK;
      prev_keys_q <= '0;
    end else begin
      if (cfg_i.valid) tps_q <= cfg_i.data;
      if (item_in_i.ready) in_v_q <= item_in_i.valid;
      if (adv) out_v_q <= in_v_q;
      if (fire) begin
        tick_q      <= tick_d;
        sec_u_q     <= sec_u_d;
        sec_t_q     <= sec_t_d;
        min_q       <= min_d;
        hour_q      <= hour_d;
        amin_q      <= amin_d;
        ahour_q     <= ahour_d;
        mark_q      <= mark_d;
        ringing_q   <= ringing_d;
        alarm_on_q  <= alarm_on_d;
        ampm_q      <= ampm_d;
        mode_q      <= mode_d;
        prev_keys_q <= keys_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (item_in_i.ready && item_in_i.valid) keys_q <= item_in_i.data.key_levels;
    if (fire) out_q <= out_d;
  end

  `BAC_ASSERT_NEXT(a_fire_loads_out, clk_i, rst_ni, fire, out_v_q)
  `BAC_ASSERT_NOW(a_buzzer_exclusive, clk_i, rst_ni, out_v_q,
                  !(out_q.buzzer_start && out_q.buzzer_stop))
  `BAC_ASSERT_NOW(a_digits_blank, clk_i, rst_ni, out_v_q && !out_q.display_update,
                  out_q.shown_hour_units == 4'd0 && out_q.shown_minute_units == 4'd0)
  `BAC_ASSERT_NOW(a_time_in_range, clk_i, rst_ni, 1'b1,
                  sec_t_q <= 3'd5 && sec_u_q <= 4'd9 && min_q.tens <= 3'd5)

endmodule
